// ===== design/mhbf_pkg.sv =====
// ---------------------------------------------------------------------------
// Height buffer fragment interpolator: shared types and constants
// Item layouts, pixel entry layout, sequencer states and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package mhbf_pkg;

  // Field and datapath widths.
  localparam int COORD_W  = 32;            // signed Q16.16 coordinate
  localparam int FRAC_W   = 16;            // fraction bits of a coordinate
  localparam int PIX_W    = 9;             // pixel column or row
  localparam int DIM_W    = 10;            // image size register
  localparam int SLOTS    = 3;             // triangle vertices a, b, c
  localparam int DIFF_W   = PIX_W + 1;     // pixel difference, signed
  localparam int MUL_W    = 2 * DIFF_W;    // product of two pixel differences
  localparam int DET_W    = MUL_W + 1;     // determinant and edge functions
  localparam int SQ_W     = MUL_W;         // squared pixel distance
  localparam int CDIFF_W  = COORD_W + 1;   // coordinate difference, signed
  localparam int PROD_W   = DET_W + CDIFF_W;
  localparam int SUMP_W   = PROD_W + 1;
  localparam int NUM_W    = PROD_W + 3;    // 2*S + |D|, signed
  localparam int DIV_W    = 56;            // dividend and quotient
  localparam int DEN_W    = 22;            // divisor
  localparam int SUM_W    = DIV_W + 2;     // base plus offset before saturation
  localparam int RATIO_W  = 26;            // unsigned Q10.16 distance ratio
  localparam int ROOT_N_W = 2 * RATIO_W;   // radicand
  localparam int SQRT_W   = ROOT_N_W + 1;
  localparam int ROOT_SHIFT = 32;          // ratio radicand is (nx << 32) / nc
  localparam int ALONG_W  = CDIFF_W + RATIO_W + 1;
  localparam int CNT_W    = 6;             // iteration counter

  localparam logic [DIM_W-1:0] DIM_RESET = 10'd512;
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FRAG = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_BARY,
    MODE_ALONG,
    MODE_NONE
  } interp_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEOM,
    ST_MUL,
    ST_NUM,
    ST_DIV,
    ST_QUOT,
    ST_SQRT,
    ST_ALONG_MUL,
    ST_ALONG_SUM,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic [1:0]                vertex_slot;
    logic [PIX_W-1:0]          pix_x;
    logic [PIX_W-1:0]          pix_y;
    logic signed [COORD_W-1:0] coord_east;
    logic signed [COORD_W-1:0] coord_north;
    logic signed [COORD_W-1:0] coord_height;
  } in_item_t;

  typedef struct packed {
    logic                      pixel_written;
    logic                      out_of_range;
    logic signed [COORD_W-1:0] stored_east;
    logic signed [COORD_W-1:0] stored_north;
    logic signed [COORD_W-1:0] stored_height;
  } out_item_t;

  // One vertex or one buffer pixel.
  typedef struct packed {
    logic signed [COORD_W-1:0] east;
    logic signed [COORD_W-1:0] north;
    logic signed [COORD_W-1:0] height;
  } coord3_t;

  // Select east, north or height by component index.
  function automatic logic signed [COORD_W-1:0] coord_pick(coord3_t c, logic [1:0] k);
    logic signed [COORD_W-1:0] r;
    case (k)
      2'd0:    r = c.east;
      2'd1:    r = c.north;
      default: r = c.height;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to the coordinate range.
  function automatic logic signed [COORD_W-1:0] coord_sat(logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = COORD_MIN;
    end else begin
      r = COORD_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/max_height_buffer_fragment_interp.sv =====
// ---------------------------------------------------------------------------
// Height buffer depth test with barycentric interpolation
// Keeps the current triangle, interpolates east, north and height at a
// fragment pixel and keeps the highest surface in a pixel memory.
// ---------------------------------------------------------------------------
//
//  Channel  Signals                         Moves
//  -------  ------------------------------  -------------------------------
//  in       in_valid / in_ready / in_data   vertex load, fragment or read
//  out      out_valid / out_ready/ out_data one result per fragment or read
//  cfg      cfg_we / cfg_index / cfg_data   image_width, image_height
//
//  A vertex load is stored while idle. An in-range read goes through the
//  read, check and done states. A fragment runs three 56-step divisions on
//  the shared one-bit-per-cycle divider for a proper triangle, and one
//  division plus a 26-step square root for a triangle with two coinciding
//  vertices. After reset a clearing pass writes every pixel; no transfer is
//  accepted during it. The result waits in an output register; the block
//  returns to idle as soon as that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module max_height_buffer_fragment_interp #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mhbf_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mhbf_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_we,
  input  wire mhbf_pkg::cfg_reg_t             cfg_index,
  input  wire logic [mhbf_pkg::DIM_W-1:0]     cfg_data
);

  import mhbf_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0]  SQRT_LAST  = CNT_W'(RATIO_W - 1);
  localparam logic [1:0]        LAST_COMP  = 2'(SLOTS - 1);
  localparam logic [SQRT_W-1:0] SQ_BIT0    = SQRT_W'(1) << (2 * (RATIO_W - 1));
  localparam int                HALF_LSB   = 1 << (FRAC_W - 1);
  localparam coord3_t CLEAR_ENTRY = '{east: '0, north: '0, height: COORD_MIN};

  // Control and configuration state.
  state_t               state, state_next;
  logic [DIM_W-1:0]     image_width, image_height;
  logic [ADDR_W-1:0]    clr_addr;
  logic [CNT_W-1:0]     cnt;
  logic [1:0]           comp;
  logic                 in_fire, out_free, pix_oor;
  logic                 mem_we, mem_re;

  // Triangle.
  coord3_t              vert   [SLOTS];
  logic [PIX_W-1:0]     vert_x [SLOTS];
  logic [PIX_W-1:0]     vert_y [SLOTS];

  // Current item and its arithmetic.
  in_item_t             req;
  logic [ADDR_W-1:0]    addr;
  interp_mode_t         mode;
  logic                 far_c;
  logic signed [DET_W-1:0]   det, an, bn;
  logic signed [PROD_W-1:0]  pa, pb;
  logic [DIV_W-1:0]     div_quo;
  logic [DEN_W-1:0]     div_den, div_rem;
  logic                 div_neg;
  logic [SQRT_W-1:0]    sq_n, sq_r, sq_bit;
  logic signed [ALONG_W-1:0] aprod;
  logic signed [COORD_W-1:0] vals [SLOTS];
  out_item_t            res;

  // Pixel memory.
  coord3_t              mem [DEPTH];
  coord3_t              mem_q, mem_wdata;
  logic [ADDR_W-1:0]    mem_waddr;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Range test against the buffer in use.
  assign pix_oor = !(({1'b0, in_data.pix_x} < image_width) && (int'(in_data.pix_x) < MAX_WIDTH) &&
                     ({1'b0, in_data.pix_y} < image_height) &&
                     (int'(in_data.pix_y) < MAX_HEIGHT));

  // Pixel differences relative to vertex a.
  logic signed [DIFF_W-1:0] px, py, ux, uy, vx, vy, fx, fy;
  assign px = $signed({1'b0, req.pix_x})  - $signed({1'b0, vert_x[0]});
  assign py = $signed({1'b0, req.pix_y})  - $signed({1'b0, vert_y[0]});
  assign ux = $signed({1'b0, vert_x[2]}) - $signed({1'b0, vert_x[0]});
  assign uy = $signed({1'b0, vert_y[2]}) - $signed({1'b0, vert_y[0]});
  assign vx = $signed({1'b0, vert_x[1]}) - $signed({1'b0, vert_x[0]});
  assign vy = $signed({1'b0, vert_y[1]}) - $signed({1'b0, vert_y[0]});

  // Degenerate triangle classification.
  logic aeqb, aeqc, ceqb, far_to_c, far_to_b;
  assign aeqb     = (vx == '0) && (vy == '0);
  assign aeqc     = (ux == '0) && (uy == '0);
  assign ceqb     = (vert_x[2] == vert_x[1]) && (vert_y[2] == vert_y[1]);
  assign far_to_c = (aeqb || ceqb) && !aeqc;
  assign far_to_b = aeqc && !aeqb;
  assign fx       = far_to_c ? ux : vx;
  assign fy       = far_to_c ? uy : vy;

  // Determinant, edge functions and squared distances.
  logic signed [MUL_W-1:0] m_uyvx, m_uxvy, m_pyvx, m_pxvy, m_pxuy, m_pyux;
  logic signed [MUL_W-1:0] m_pxpx, m_pypy, m_fxfx, m_fyfy;
  logic signed [DET_W-1:0] det_c, an_c, bn_c;
  logic [SQ_W-1:0]         nx_c, nc_c;
  assign m_uyvx = uy * vx;
  assign m_uxvy = ux * vy;
  assign m_pyvx = py * vx;
  assign m_pxvy = px * vy;
  assign m_pxuy = px * uy;
  assign m_pyux = py * ux;
  assign m_pxpx = px * px;
  assign m_pypy = py * py;
  assign m_fxfx = fx * fx;
  assign m_fyfy = fy * fy;
  assign det_c  = DET_W'(m_uyvx) - DET_W'(m_uxvy);
  assign an_c   = DET_W'(m_pyvx) - DET_W'(m_pxvy);
  assign bn_c   = DET_W'(m_pxuy) - DET_W'(m_pyux);
  assign nx_c   = $unsigned(m_pxpx) + $unsigned(m_pypy);
  assign nc_c   = $unsigned(m_fxfx) + $unsigned(m_fyfy);

  // Coordinates of the component in work.
  logic signed [COORD_W-1:0] ca, cb, cc;
  logic signed [CDIFF_W-1:0] dc, db, dfar;
  assign ca   = coord_pick(vert[0], comp);
  assign cb   = coord_pick(vert[1], comp);
  assign cc   = coord_pick(vert[2], comp);
  assign dc   = CDIFF_W'(cc) - CDIFF_W'(ca);
  assign db   = CDIFF_W'(cb) - CDIFF_W'(ca);
  assign dfar = far_c ? dc : db;

  // Rounded numerator 2*S + |D| with S carrying the sign of D.
  logic signed [SUMP_W-1:0] s_sum, s_adj;
  logic signed [DET_W-1:0]  abs_det;
  logic signed [NUM_W-1:0]  n_c, n_abs;
  assign s_sum   = SUMP_W'(pa) + SUMP_W'(pb);
  assign s_adj   = det[DET_W-1] ? -s_sum : s_sum;
  assign abs_det = det[DET_W-1] ? -det : det;
  assign n_c     = (NUM_W'(s_adj) <<< 1) + NUM_W'(abs_det);
  assign n_abs   = n_c[NUM_W-1] ? -n_c : n_c;

  // One restoring division step.
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             fits;
  logic [DIV_W-1:0] quo_step;
  logic [DEN_W-1:0] rem_step;
  assign rem_sh   = {div_rem, div_quo[DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, div_den};
  assign fits     = !rem_sub[DEN_W];
  assign quo_step = {div_quo[DIV_W-2:0], fits};
  assign rem_step = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  // Floor quotient and interpolated value.
  logic signed [SUM_W-1:0] q_mag, q_val, bary_sum;
  assign q_mag    = {2'b00, div_quo} + SUM_W'(div_neg && (div_rem != '0));
  assign q_val    = div_neg ? -q_mag : q_mag;
  assign bary_sum = SUM_W'(ca) + q_val;

  // One square root step.
  logic [SQRT_W-1:0] sq_trial;
  logic              sq_ge;
  assign sq_trial = sq_r + sq_bit;
  assign sq_ge    = sq_n >= sq_trial;

  // Value along an edge by the distance ratio.
  logic signed [ALONG_W-1:0] a_rnd, a_shift;
  logic signed [SUM_W-1:0]   along_sum;
  assign a_rnd     = aprod + ALONG_W'(HALF_LSB);
  assign a_shift   = a_rnd >>> FRAC_W;
  assign along_sum = SUM_W'(ca) + SUM_W'(a_shift);

  // Depth test.
  logic win;
  assign win = (req.op == OP_FRAG) && (mode != MODE_NONE) && (vals[2] > mem_q.height);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory strobes.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_data.op == OP_FRAG || in_data.op == OP_READ)) begin
          if (pix_oor) state_next = ST_DONE;
          else if (in_data.op == OP_FRAG) state_next = ST_GEOM;
          else state_next = ST_READ;
        end
      end
      ST_GEOM: begin
        if (det_c != '0) state_next = ST_MUL;
        else if (far_to_c || far_to_b) state_next = ST_DIV;
        else state_next = ST_READ;
      end
      ST_MUL:  state_next = ST_NUM;
      ST_NUM:  state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == DIV_LAST) state_next = (mode == MODE_BARY) ? ST_QUOT : ST_SQRT;
      end
      ST_QUOT: state_next = (comp == LAST_COMP) ? ST_READ : ST_MUL;
      ST_SQRT: begin
        if (cnt == SQRT_LAST) state_next = ST_ALONG_MUL;
      end
      ST_ALONG_MUL: state_next = ST_ALONG_SUM;
      ST_ALONG_SUM: state_next = (comp == LAST_COMP) ? ST_READ : ST_ALONG_MUL;
      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        mem_we     = win;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Triangle vertices.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        vert[i]   <= '0;
        vert_x[i] <= '0;
        vert_y[i] <= '0;
      end
    end else if (in_fire && in_data.op == OP_LOAD && in_data.vertex_slot < 2'(SLOTS)) begin
      vert_x[in_data.vertex_slot] <= in_data.pix_x;
      vert_y[in_data.vertex_slot] <= in_data.pix_y;
      vert[in_data.vertex_slot]   <= '{east:   in_data.coord_east,
                                       north:  in_data.coord_north,
                                       height: in_data.coord_height};
    end
  end

  // Clearing address, iteration counter and component index.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      cnt      <= '0;
      comp     <= '0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      case (state)
        ST_GEOM, ST_NUM: cnt <= '0;
        ST_DIV:  cnt <= (cnt == DIV_LAST) ? '0 : cnt + 1'b1;
        ST_SQRT: cnt <= cnt + 1'b1;
        default: ;
      endcase
      if (state == ST_GEOM) begin
        comp <= '0;
      end else if ((state == ST_QUOT || state == ST_ALONG_SUM) && comp != LAST_COMP) begin
        comp <= comp + 1'b1;
      end
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          req  <= in_data;
          addr <= ADDR_W'(in_data.pix_y) * ROW_STRIDE + ADDR_W'(in_data.pix_x);
          res  <= '{pixel_written: 1'b0, out_of_range: 1'b1,
                    stored_east: '0, stored_north: '0, stored_height: '0};
        end
      end
      ST_GEOM: begin
        det   <= det_c;
        an    <= an_c;
        bn    <= bn_c;
        far_c <= far_to_c;
        if (det_c != '0) mode <= MODE_BARY;
        else if (far_to_c || far_to_b) mode <= MODE_ALONG;
        else mode <= MODE_NONE;
        // Ratio division (nx << 32) / nc for the degenerate case.
        div_quo <= DIV_W'({nx_c, {ROOT_SHIFT{1'b0}}});
        div_den <= DEN_W'(nc_c);
        div_rem <= '0;
        div_neg <= 1'b0;
      end
      ST_MUL: begin
        pa <= an * dc;
        pb <= bn * db;
      end
      ST_NUM: begin
        div_quo <= n_abs[DIV_W-1:0];
        div_den <= DEN_W'({abs_det, 1'b0});
        div_rem <= '0;
        div_neg <= n_c[NUM_W-1];
      end
      ST_DIV: begin
        div_quo <= quo_step;
        div_rem <= rem_step;
        if (cnt == DIV_LAST) begin
          sq_n   <= SQRT_W'(quo_step[ROOT_N_W-1:0]);
          sq_r   <= '0;
          sq_bit <= SQ_BIT0;
        end
      end
      ST_QUOT: vals[comp] <= coord_sat(bary_sum);
      ST_SQRT: begin
        sq_n   <= sq_ge ? sq_n - sq_trial : sq_n;
        sq_r   <= sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;
        sq_bit <= sq_bit >> 2;
      end
      ST_ALONG_MUL: aprod <= dfar * $signed({1'b0, sq_r[RATIO_W-1:0]});
      ST_ALONG_SUM: vals[comp] <= coord_sat(along_sum);
      ST_CHECK: begin
        res.pixel_written <= win;
        res.out_of_range  <= 1'b0;
        res.stored_east   <= win ? vals[0] : mem_q.east;
        res.stored_north  <= win ? vals[1] : mem_q.north;
        res.stored_height <= win ? vals[2] : mem_q.height;
      end
      default: ;
    endcase
  end

  // Pixel memory: one write port, one registered read port.
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : addr;
  assign mem_wdata = (state == ST_CLEAR) ? CLEAR_ENTRY
                                         : '{east: vals[0], north: vals[1], height: vals[2]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[addr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) out_data <= res;
  end

  // A written pixel is always inside the buffer.
  a_written_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pixel_written |-> !out_data.out_of_range)
    else $error("written pixel flagged out of range");

  // Out of range results carry zero fields.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_of_range |->
      out_data.stored_east == '0 && out_data.stored_north == '0 &&
      out_data.stored_height == '0)
    else $error("out of range result with nonzero fields");

  // A winning fragment lies strictly above the cleared height.
  a_win_above_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pixel_written |-> out_data.stored_height != COORD_MIN)
    else $error("fragment won at the minimum height");

  // The divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_rem < div_den)
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
